// File: rtl/core/rpdc_pkg.sv
// ----------------------------------------------------------------------------
// rpdc_pkg
// shared types, constants and the crc-16 byte step for the packet deframer
// ----------------------------------------------------------------------------
package rpdc_pkg;

   localparam int MAX_LEN_DEF = 64;
   localparam int LEN_W       = 7;
   localparam int BYTE_W      = 8;
   localparam int CRC_W       = 16;

   localparam logic [LEN_W-1:0] CRC_BYTES = 7'd2;
   localparam logic [CRC_W-1:0] CRC_INIT  = 16'hFFFF;
   localparam logic [CRC_W-1:0] CRC_POLY  = 16'hA001;

   typedef enum logic [1:0] {
      STAT_BYTE      = 2'd0,
      STAT_CRC_ERR   = 2'd1,
      STAT_LEN_REJ   = 2'd2,
      STAT_SYNC_LOST = 2'd3
   } rsp_status_type;

   typedef enum logic [1:0] {
      OSEL_LEN  = 2'd0,
      OSEL_DATA = 2'd1,
      OSEL_ZERO = 2'd2
   } out_sel_type;

   typedef struct packed {
      logic           load_len;
      logic           take_byte;
      logic           crc_clear;
      logic           rd_start;
      logic           rd_next;
      logic           out_load;
      out_sel_type    out_sel;
      rsp_status_type out_status;
      logic           out_last;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic len_bad;
      logic body_done;
      logic crc_zero;
      logic plen_zero;
      logic emit_last;
   } dp_stat_type;

   // reflected crc-16, one byte, lsb first
   function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] c,
                                                 input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] r;
      r = c ^ {8'h00, b};
      for (int i = 0; i < BYTE_W; i++) begin
         if (r[0]) begin
            r = (r >> 1) ^ CRC_POLY;
         end else begin
            r = r >> 1;
         end
      end
      return r;
   endfunction

endpackage

// File: rtl/core/radio_packet_rx_deframer_crc.sv
// ----------------------------------------------------------------------------
// radio_packet_rx_deframer_crc
// length-prefixed packet deframer with reflected crc-16 check
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  req      in   req_valid/req_stall  req_sync_good, req_rx_byte
//  rsp      out  rsp_valid/rsp_stall  rsp_out_byte, rsp_status, rsp_last
//
//  one input transfer per cycle while receiving a packet and not stalled; crc updated per byte
//  a good packet's final byte is followed by L-1 result transfers: the payload length,
//  then payload bytes from the packet store read port, one per unstalled cycle;
//  input is held off meanwhile; error statuses take a single result transfer
//  rsp_stall holds the result register and with it the input side
//  synchronous reset returns to waiting for a length; no clearing pass
// ----------------------------------------------------------------------------
module radio_packet_rx_deframer_crc #(
   parameter int MAX_LEN = rpdc_pkg::MAX_LEN_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_sync_good,
   input  logic [rpdc_pkg::BYTE_W-1:0] req_rx_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [rpdc_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic [1:0]                  rsp_status,
   output logic                        rsp_last
);
   import rpdc_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   rpdc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sync_good (req_sync_good),
      .stat          (stat),
      .cmd           (cmd)
   );

   rpdc_datapath #(
      .MAX_LEN (MAX_LEN)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_rx_byte  (req_rx_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last)
   );

endmodule

// File: rtl/core/rpdc_datapath.sv
// ----------------------------------------------------------------------------
// rpdc_datapath
// length and count registers, crc, packet store and the result register
// ----------------------------------------------------------------------------
module rpdc_datapath #(
   parameter int MAX_LEN = rpdc_pkg::MAX_LEN_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rpdc_pkg::dp_cmd_type          cmd,
   output rpdc_pkg::dp_stat_type         stat,
   input  logic [rpdc_pkg::BYTE_W-1:0]   req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rpdc_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_last
);
   import rpdc_pkg::*;

   localparam int AW = $clog2(MAX_LEN);

   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic [CRC_W-1:0]  crc_ff, crc_in;
   logic [CRC_W-1:0]  crc_next;
   logic [AW-1:0]     rd_idx_ff, rd_idx_in;
   logic [AW-1:0]     rd_addr;
   logic [AW-1:0]     wr_addr;
   logic [BYTE_W-1:0] rd_data_ff;
   logic [BYTE_W-1:0] store [MAX_LEN];
   logic [LEN_W-1:0]  wr_pos;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic [1:0]        status_ff, status_in;
   logic              last_ff, last_in;

   assign crc_next = crc_step(crc_ff, req_rx_byte);
   assign wr_pos   = count_ff - 7'd1;
   assign wr_addr  = wr_pos[AW-1:0];
   assign rd_addr  = cmd.rd_start ? '0 : AW'(rd_idx_ff + 1'b1);

   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;
   assign stat.len_bad   = (req_rx_byte > BYTE_W'(MAX_LEN)) ||
                           (req_rx_byte < {1'b0, CRC_BYTES});
   assign stat.body_done = (count_ff == len_ff);
   assign stat.crc_zero  = (crc_next == '0);
   assign stat.plen_zero = (len_ff == CRC_BYTES);
   assign stat.emit_last = (LEN_W'(rd_idx_ff) == (len_ff - 7'd3));

   always_comb begin
      len_in    = len_ff;
      count_in  = count_ff;
      crc_in    = crc_ff;
      rd_idx_in = rd_idx_ff;
      if (cmd.load_len) begin
         len_in   = req_rx_byte[LEN_W-1:0];
         count_in = 7'd1;
         crc_in   = crc_step(CRC_INIT, req_rx_byte);
      end
      if (cmd.take_byte) begin
         count_in = count_ff + 7'd1;
         crc_in   = crc_next;
      end
      if (cmd.crc_clear) begin
         crc_in = CRC_INIT;
      end
      if (cmd.rd_start || cmd.rd_next) begin
         rd_idx_in = rd_addr;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_byte_in  = out_byte_ff;
      status_in    = status_ff;
      last_in      = last_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         status_in    = cmd.out_status;
         last_in      = cmd.out_last;
         case (cmd.out_sel)
            OSEL_LEN: begin
               out_byte_in = BYTE_W'(len_ff - CRC_BYTES);
            end
            OSEL_DATA: begin
               out_byte_in = rd_data_ff;
            end
            default: begin
               out_byte_in = '0;
            end
         endcase
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= CRC_INIT;
         count_ff     <= '0;
         len_ff       <= '0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         count_ff     <= count_in;
         len_ff       <= len_in;
         rd_idx_ff    <= rd_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      status_ff   <= status_in;
      last_ff     <= last_in;
   end

   // packet store
   always_ff @(posedge clock) begin
      if (cmd.take_byte) begin
         store[wr_addr] <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_start || cmd.rd_next) begin
         rd_data_ff <= store[rd_addr];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_status   = status_ff;
   assign rsp_last     = last_ff;

endmodule

// File: rtl/core/rpdc_ctrl.sv
// ----------------------------------------------------------------------------
// rpdc_ctrl
// packet state machine: length, body and emission phases
// ----------------------------------------------------------------------------
module rpdc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_sync_good,
   input  rpdc_pkg::dp_stat_type stat,
   output rpdc_pkg::dp_cmd_type  cmd
);
   import rpdc_pkg::*;

   typedef enum logic [2:0] {
      ST_LEN  = 3'b001,
      ST_BODY = 3'b010,
      ST_EMIT = 3'b100
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           accept;

   assign req_stall = (state_ff == ST_EMIT) || !stat.out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.out_sel    = OSEL_ZERO;
      cmd.out_status = STAT_BYTE;
      case (state_ff)
         ST_LEN: begin
            if (accept && req_sync_good) begin
               if (stat.len_bad) begin
                  cmd.out_load   = 1'b1;
                  cmd.out_status = STAT_LEN_REJ;
                  cmd.out_last   = 1'b1;
               end else begin
                  cmd.load_len = 1'b1;
                  state_in     = ST_BODY;
               end
            end
         end
         ST_BODY: begin
            if (accept && !req_sync_good) begin
               cmd.crc_clear  = 1'b1;
               cmd.out_load   = 1'b1;
               cmd.out_status = STAT_SYNC_LOST;
               cmd.out_last   = 1'b1;
               state_in       = ST_LEN;
            end else if (accept) begin
               cmd.take_byte = 1'b1;
               if (stat.body_done) begin
                  cmd.crc_clear = 1'b1;
                  cmd.out_load  = 1'b1;
                  state_in      = ST_LEN;
                  if (stat.crc_zero) begin
                     cmd.out_sel  = OSEL_LEN;
                     cmd.out_last = stat.plen_zero;
                     cmd.rd_start = 1'b1;
                     if (!stat.plen_zero) begin
                        state_in = ST_EMIT;
                     end
                  end else begin
                     cmd.out_status = STAT_CRC_ERR;
                     cmd.out_last   = 1'b1;
                  end
               end
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OSEL_DATA;
               cmd.out_last = stat.emit_last;
               if (stat.emit_last) begin
                  state_in = ST_LEN;
               end else begin
                  cmd.rd_next = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_LEN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LEN;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/core/rpdc_checker.sv
// ----------------------------------------------------------------------------
// rpdc_checker
// port-level checks on the deframer result channel
// ----------------------------------------------------------------------------
module rpdc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic [1:0] rsp_status,
   input logic       rsp_last
);
   import rpdc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) &&
         $stable(rsp_status) && $stable(rsp_last))
      else $error("stalled result changed");

   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_BYTE |-> rsp_last && rsp_out_byte == 8'h00)
      else $error("error status not a single zero result");

   a_more_is_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_status == STAT_BYTE)
      else $error("non-final result is not a packet byte");

   a_more_blocks_in: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("input taken while a packet is still being emitted");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind radio_packet_rx_deframer_crc rpdc_checker u_rpdc_checker (.*);

// File: tb/sv/tb_radio_packet_rx_deframer_crc.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_radio_packet_rx_deframer_crc
// self-checking bench for the length-prefixed crc-16 packet deframer: drives
// received bytes with random gaps, predicts every result transfer from a
// local model of the deframer and checks each one field by field
// ----------------------------------------------------------------------------
module tb_radio_packet_rx_deframer_crc;
   import rpdc_pkg::*;

   localparam int FRAME_MAX  = MAX_LEN_DEF;
   localparam int ITEM_GOAL  = 270;
   localparam int QUIET_MAX  = 1000;
   localparam int DRAIN_WAIT = 100;

   typedef struct {
      logic [7:0]     data;
      rsp_status_type status;
      logic           last;
   } deframe_rsp_type;

   logic       clock;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_stall;
   logic       req_sync_good = 1'b0;
   logic [7:0] req_rx_byte   = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall     = 1'b0;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_status;
   logic       rsp_last;

   // predicted deframer state
   logic [6:0]  rx_count = '0;
   logic [6:0]  rx_len   = '0;
   logic [15:0] rx_crc   = CRC_INIT;
   logic [7:0]  rx_store [FRAME_MAX];

   deframe_rsp_type deframed_q[$];
   deframe_rsp_type want;
   int           error_count = 0;
   int           item_count  = 0;
   int           stall_left  = 0;
   int           quiet_count = 0;
   bit           idle_on     = 1'b1;

   radio_packet_rx_deframer_crc #(.MAX_LEN(FRAME_MAX)) DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sync_good (req_sync_good),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] r;
      r = acc ^ {8'h00, b};
      repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      return r;
   endfunction

   task automatic push_rsp(input logic [7:0] data, input rsp_status_type status,
                           input logic last);
      deframe_rsp_type r;
      r.data   = data;
      r.status = status;
      r.last   = last;
      deframed_q.push_back(r);
   endtask

   task automatic deframe_byte(input logic sync, input logic [7:0] b);
      int plen;
      if (!sync) begin
         if (rx_count != 0) begin
            rx_count = '0;
            rx_crc   = CRC_INIT;
            push_rsp(8'h00, STAT_SYNC_LOST, 1'b1);
         end
      end else if (rx_count == 0) begin
         if (b > FRAME_MAX || b < CRC_BYTES) begin
            rx_crc = CRC_INIT;
            push_rsp(8'h00, STAT_LEN_REJ, 1'b1);
         end else begin
            rx_len   = b[6:0];
            rx_crc   = crc16_update(CRC_INIT, b);
            rx_count = 7'd1;
         end
      end else begin
         rx_crc = crc16_update(rx_crc, b);
         rx_store[rx_count - 1] = b;
         if (rx_count < rx_len) begin
            rx_count = rx_count + 7'd1;
         end else begin
            if (rx_crc == 16'h0000) begin
               plen = int'(rx_len) - int'(CRC_BYTES);
               push_rsp(8'(plen), STAT_BYTE, plen == 0);
               for (int i = 0; i < plen; i++) begin
                  push_rsp(rx_store[i], STAT_BYTE, i + 1 == plen);
               end
            end else begin
               push_rsp(8'h00, STAT_CRC_ERR, 1'b1);
            end
            rx_count = '0;
            rx_crc   = CRC_INIT;
         end
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      error_count++;
   endtask

   task automatic send_item(input logic sync, input logic [7:0] b);
      int gap;
      gap = idle_on ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sync_good <= sync;
      req_rx_byte   <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (sync || rx_count != 0) item_count++;
      deframe_byte(sync, b);
   endtask

   // flip_pos picks a body byte (1..L) to corrupt, cut_after drops sync after
   // that many body bytes; -1 disables either
   task automatic send_frame(input logic [7:0] payload[$], input int flip_pos,
                             input int cut_after);
      logic [7:0]  frame[$];
      logic [15:0] crc;
      int          len;
      len = payload.size() + 2;
      frame.push_back(8'(len));
      crc = crc16_update(CRC_INIT, 8'(len));
      foreach (payload[i]) begin
         frame.push_back(payload[i]);
         crc = crc16_update(crc, payload[i]);
      end
      frame.push_back(crc[7:0]);
      frame.push_back(crc[15:8]);
      if (flip_pos > 0) frame[flip_pos] = frame[flip_pos] ^ (8'd1 << $urandom_range(0, 7));
      if (cut_after >= 0) begin
         for (int i = 0; i <= cut_after; i++) send_item(1'b1, frame[i]);
         send_item(1'b0, 8'($urandom));
      end else begin
         foreach (frame[i]) send_item(1'b1, frame[i]);
      end
   endtask

   task automatic test_length_reject;
      send_item(1'b1, 8'd0);
      send_item(1'b1, 8'd1);
      send_item(1'b1, 8'd65);
      send_item(1'b1, 8'd128);
      send_item(1'b1, 8'd255);
   endtask

   task automatic test_idle_sync_loss;
      send_item(1'b0, 8'hFF);
      send_item(1'b0, 8'h00);
   endtask

   task automatic test_empty_packet;
      logic [7:0] none[$];
      send_frame(none, -1, -1);
   endtask

   task automatic test_payload_extremes;
      logic [7:0] body[$];
      body = '{8'h00, 8'hFF, 8'h55, 8'hAA};
      send_frame(body, -1, -1);
   endtask

   task automatic test_crc_error;
      logic [7:0] body[$];
      body = '{8'h3C};
      send_frame(body, 2, -1);
   endtask

   task automatic test_sync_lost_mid;
      logic [7:0] body[$];
      body = '{8'h12, 8'h34, 8'h56};
      send_frame(body, -1, 2);
   endtask

   task automatic test_random_traffic;
      logic [7:0] body[$];
      int         frame_no;
      int         pick;
      int         plen;
      frame_no = 0;
      while (item_count < ITEM_GOAL) begin
         idle_on = ($urandom_range(0, 3) != 0);
         pick    = $urandom_range(0, 99);
         if (frame_no == 3) begin
            plen = FRAME_MAX - 2;
         end else if (frame_no % 16 == 11) begin
            plen = $urandom_range(30, FRAME_MAX - 2);
         end else begin
            plen = $urandom_range(0, 10);
         end
         body.delete();
         for (int i = 0; i < plen; i++) body.push_back(8'($urandom));
         if (pick < 70) begin
            send_frame(body, -1, -1);
         end else if (pick < 80) begin
            send_frame(body, $urandom_range(1, plen + 2), -1);
         end else if (pick < 88) begin
            send_frame(body, -1, $urandom_range(0, plen + 1));
         end else if (pick < 94) begin
            if ($urandom_range(0, 1) == 0) begin
               send_item(1'b1, 8'($urandom_range(0, 1)));
            end else begin
               send_item(1'b1, 8'($urandom_range(FRAME_MAX + 1, 255)));
            end
         end else begin
            send_item(1'b0, 8'($urandom));
         end
         frame_no++;
      end
   endtask

   // result side stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) stall_left = idle_on ? $urandom_range(0, 13) : 0;
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (deframed_q.size() == 0) begin
            report_mismatch($sformatf("unexpected transfer byte %02h status %0d last %0b",
                                      rsp_out_byte, rsp_status, rsp_last));
         end else begin
            want = deframed_q.pop_front();
            if (rsp_out_byte !== want.data)
               report_mismatch($sformatf("out_byte %02h, want %02h", rsp_out_byte, want.data));
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d", rsp_status, want.status));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last %0b, want %0b", rsp_last, want.last));
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_count <= 0;
      end else if (quiet_count >= QUIET_MAX) begin
         $display("timeout: no transfer for %0d cycles", QUIET_MAX);
         $display("radio_packet_rx_deframer_crc verification failed");
         $finish;
      end else begin
         quiet_count <= quiet_count + 1;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_length_reject;
      test_idle_sync_loss;
      test_empty_packet;
      test_payload_extremes;
      test_crc_error;
      test_sync_lost_mid;
      test_random_traffic;
      req_valid <= 1'b0;
      while (deframed_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("radio_packet_rx_deframer_crc verification clean");
      end else begin
         $display("radio_packet_rx_deframer_crc verification failed");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/rpdc_pkg.sv
rtl/core/rpdc_datapath.sv
rtl/core/rpdc_ctrl.sv
rtl/core/radio_packet_rx_deframer_crc.sv
rtl/core/rpdc_checker.sv
tb/sv/tb_radio_packet_rx_deframer_crc.sv
